// File: hw/rtl/sts_pkg.sv
// sts_pkg: shared types, constants and the envelope follower function of the
// stereo transient shaper. No dependencies.
`default_nettype none

package sts_pkg;

  // fixed frame layout and field widths
  localparam int unsigned NUM_CH          = 2;
  localparam int unsigned DEF_CHANNELS    = 2;
  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned ENV_W           = 25;
  localparam int unsigned COEF_W          = 24;
  localparam int unsigned FACTOR_W        = 16;
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 24;

  // envelope full scale, 1.0 in Q1.24
  localparam logic [ENV_W-1:0] ENV_ONE = 25'h100_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATK_FAST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATK_SLOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOLO     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 3'd6;

  // register reset values
  localparam logic [COEF_W-1:0]          RST_ATK_FAST = 24'd15099494;
  localparam logic [COEF_W-1:0]          RST_ATK_SLOW = 24'd16609443;
  localparam logic [COEF_W-1:0]          RST_RELEASE  = 24'd16760439;
  localparam logic signed [FACTOR_W-1:0] RST_FACTOR   = 16'sd4096;
  localparam logic [GAIN_W-1:0]          RST_GAIN     = 16'd4096;

  // configuration seen by every lane
  typedef struct packed {
    logic [COEF_W-1:0]          atk_fast;
    logic [COEF_W-1:0]          atk_slow;
    logic [COEF_W-1:0]          rel;
    logic signed [FACTOR_W-1:0] factor;
    logic [GAIN_W-1:0]          gain;
    logic                       solo;
    logic                       bypass;
  } sts_cfg_t;

  // per-step strobes from the sequencer to the lanes
  typedef struct packed {
    logic step_env;
    logic step_xd;
    logic step_term;
  } sts_ctrl_t;

  // one peak follower update: attack above the envelope, release below,
  // rounded and clipped to [0, 1.0]
  function automatic logic [ENV_W-1:0] sts_follow(
    input logic [ENV_W-1:0]  env,
    input logic [ENV_W-1:0]  v,
    input logic [COEF_W-1:0] atk,
    input logic [COEF_W-1:0] rel
  );
    logic [COEF_W-1:0]       c;
    logic signed [ENV_W:0]   diff;
    logic signed [51:0]      prod;
    logic signed [51:0]      rnd;
    logic signed [ENV_W+2:0] n;
    logic [ENV_W-1:0]        res;
    c    = (v > env) ? atk : rel;
    diff = $signed({1'b0, env}) - $signed({1'b0, v});
    prod = 52'($signed({1'b0, c})) * 52'(diff);
    rnd  = (prod + 52'sd8388608) >>> 24;
    n    = $signed({3'b000, v}) + $signed(rnd[ENV_W+2:0]);
    if (n < 0) begin
      res = '0;
    end else if (n > $signed({3'b000, ENV_ONE})) begin
      res = ENV_ONE;
    end else begin
      res = n[ENV_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sts_lane.sv
// sts_lane: one channel of the shaper, envelope pair plus the gain chain.
// Depends on sts_pkg.
`default_nettype none

module sts_lane #(
  parameter int unsigned SAMPLE_BITS = sts_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire sts_pkg::sts_cfg_t             cfg_i,
  input  wire sts_pkg::sts_ctrl_t            ctrl_i,
  output logic signed [SAMPLE_BITS-1:0]      y_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned EW     = sts_pkg::ENV_W;
  localparam int unsigned MW     = (SB > EW) ? SB : EW;
  localparam int unsigned SHL    = (SB <= EW) ? EW - SB : 0;
  localparam int unsigned SHR    = (SB > EW) ? SB - EW : 0;
  localparam int unsigned P1_W   = SB + EW + 1;
  localparam int unsigned XD_W   = SB + 2;
  localparam int unsigned P2_W   = XD_W + sts_pkg::FACTOR_W;
  localparam int unsigned TERM_W = XD_W + 4;
  localparam int unsigned PRE_W  = TERM_W + 1;
  localparam int unsigned P3_W   = PRE_W + sts_pkg::GAIN_W + 1;

  localparam logic signed [P1_W-1:0] RND24 = P1_W'(24'h80_0000);
  localparam logic signed [P2_W-1:0] RND12 = P2_W'(12'h800);
  localparam logic signed [P3_W-1:0] RND12W = P3_W'(12'h800);
  localparam logic signed [P3_W-1:0] MAXV =
    {{(P3_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [P3_W-1:0] MINV = ~MAXV;

  logic [EW-1:0]                fast_q, fast_d;
  logic [EW-1:0]                slow_q, slow_d;
  logic signed [XD_W-1:0]       xd_q, xd_d;
  logic signed [TERM_W-1:0]     term_q, term_d;

  logic [SB-1:0]                mag;
  logic [MW-1:0]                mag_w;
  logic [MW-1:0]                v_w;
  logic [EW-1:0]                v;
  logic signed [EW:0]           diff;
  logic signed [P1_W-1:0]       p1, s1;
  logic signed [P2_W-1:0]       p2, s2;
  logic signed [PRE_W-1:0]      pre;
  logic signed [P3_W-1:0]       p3, s3;
  logic signed [SB-1:0]         y_sat;

  // magnitude scaled to Q1.24
  always_comb begin
    mag   = x_i[SB-1] ? (~x_i + SB'(1)) : x_i;
    mag_w = MW'(mag);
    v_w   = (mag_w << SHL) >> SHR;
    v     = v_w[EW-1:0];
  end

  // envelope update, held in bypass
  always_comb begin
    fast_d = fast_q;
    slow_d = slow_q;
    if (ctrl_i.step_env && !cfg_i.bypass) begin
      fast_d = sts_pkg::sts_follow(fast_q, v, cfg_i.atk_fast, cfg_i.rel);
      slow_d = sts_pkg::sts_follow(slow_q, v, cfg_i.atk_slow, cfg_i.rel);
    end
  end

  // x times envelope difference, rounded back to sample scale
  always_comb begin
    diff = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
    p1   = P1_W'(x_i) * P1_W'(diff);
    s1   = (p1 + RND24) >>> 24;
    xd_d = s1[XD_W-1:0];
  end

  // transient term, scaled by the factor
  always_comb begin
    p2     = P2_W'(xd_q) * P2_W'(cfg_i.factor);
    s2     = (p2 + RND12) >>> 12;
    term_d = s2[TERM_W-1:0];
  end

  // output mix (term alone in solo), gain, saturation and bypass select
  always_comb begin
    if (cfg_i.solo) begin
      pre = PRE_W'(term_q);
    end else begin
      pre = PRE_W'(term_q) + PRE_W'(x_i);
    end
    p3 = P3_W'(pre) * P3_W'($signed({1'b0, cfg_i.gain}));
    s3 = (p3 + RND12W) >>> 12;
    priority if (s3 > MAXV) begin
      y_sat = MAXV[SB-1:0];
    end else if (s3 < MINV) begin
      y_sat = MINV[SB-1:0];
    end else begin
      y_sat = s3[SB-1:0];
    end
    y_o = cfg_i.bypass ? x_i : y_sat;
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
    end else begin
      fast_q <= fast_d;
      slow_q <= slow_d;
    end
  end

  // datapath stage registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step_xd) begin
      xd_q <= xd_d;
    end
    if (ctrl_i.step_term) begin
      term_q <= term_d;
    end
  end

  // envelopes stay inside [0, 1.0]
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fast_q <= sts_pkg::ENV_ONE) && (slow_q <= sts_pkg::ENV_ONE))
    else $error("envelope above full scale");

  // envelopes move only on an enabled update step
  a_env_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.step_env && !cfg_i.bypass) |=> $stable(fast_q) && $stable(slow_q))
    else $error("envelope changed outside its update step");

endmodule

`default_nettype wire

// File: hw/rtl/sts_merge.sv
// sts_merge: output register that gathers the lane results into one frame
// and runs the output valid/stall handshake. Depends on sts_pkg.
`default_nettype none

module sts_merge #(
  parameter int unsigned SAMPLE_BITS = sts_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic signed [SAMPLE_BITS-1:0] res_i [sts_pkg::NUM_CH],
  input  wire logic                          out_stall_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]      left_result_o,
  output logic signed [SAMPLE_BITS-1:0]      right_result_o
);

  logic                         valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  // register can take a frame when empty or being drained this cycle
  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= res_i[0];
      right_q <= res_i[1];
    end
  end

  assign out_valid_o    = valid_q;
  assign left_result_o  = left_q;
  assign right_result_o = right_q;

endmodule

`default_nettype wire

// File: hw/rtl/stereo_transient_shaper.sv
// Stereo transient shaper: one frame of two samples in, one shaped frame out.
//
// Input channel: in_valid_i / in_stall_o with left_sample_i and right_sample_i;
// a transfer happens on a rising edge with valid high and stall low. Output
// channel: out_valid_o / out_stall_i with left_result_o and right_result_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 attack fast, 1 attack slow, 2 release, 3 factor, 4 gain, 5 solo,
// 6 bypass); write only while no frame is in flight.
// Each channel below CHANNELS has its own lane; the others pass through. A
// frame runs through three sequenced steps (envelope update, envelope
// difference product, factor product); the gain product and saturation feed
// the output register directly. A new frame is taken only while idle or when
// the output register loads the previous one, and out_valid_o rises once
// that register holds the frame. It holds a finished frame while the receiver
// stalls; the block then finishes the next frame and waits with it.
// Reset clears the envelopes to zero, loads the register defaults and
// empties the output register.
`default_nettype none

module stereo_transient_shaper #(
  parameter int unsigned CHANNELS    = sts_pkg::DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = sts_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      right_sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]           left_result_o,
  output logic signed [SAMPLE_BITS-1:0]           right_result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [sts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] STEP_ENV  = 2'd0;
  localparam logic [1:0] STEP_XD   = 2'd1;
  localparam logic [1:0] STEP_TERM = 2'd2;

  sts_pkg::sts_cfg_t  cfg_q;
  sts_pkg::sts_ctrl_t ctrl;

  logic [1:0] st_q, st_d;
  logic [1:0] step_q, step_d;
  logic       accept;
  logic       out_free;
  logic       load_out;

  logic signed [SAMPLE_BITS-1:0] x_q [sts_pkg::NUM_CH];
  logic signed [SAMPLE_BITS-1:0] res [sts_pkg::NUM_CH];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atk_fast <= sts_pkg::RST_ATK_FAST;
      cfg_q.atk_slow <= sts_pkg::RST_ATK_SLOW;
      cfg_q.rel      <= sts_pkg::RST_RELEASE;
      cfg_q.factor   <= sts_pkg::RST_FACTOR;
      cfg_q.gain     <= sts_pkg::RST_GAIN;
      cfg_q.solo     <= 1'b0;
      cfg_q.bypass   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sts_pkg::REG_ATK_FAST: cfg_q.atk_fast <= cfg_wdata_i[sts_pkg::COEF_W-1:0];
        sts_pkg::REG_ATK_SLOW: cfg_q.atk_slow <= cfg_wdata_i[sts_pkg::COEF_W-1:0];
        sts_pkg::REG_RELEASE:  cfg_q.rel      <= cfg_wdata_i[sts_pkg::COEF_W-1:0];
        sts_pkg::REG_FACTOR:   cfg_q.factor   <= $signed(cfg_wdata_i[sts_pkg::FACTOR_W-1:0]);
        sts_pkg::REG_GAIN:     cfg_q.gain     <= cfg_wdata_i[sts_pkg::GAIN_W-1:0];
        sts_pkg::REG_SOLO:     cfg_q.solo     <= cfg_wdata_i[0];
        sts_pkg::REG_BYPASS:   cfg_q.bypass   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign load_out   = (st_q == ST_DONE) && out_free;
  assign in_stall_o = !((st_q == ST_IDLE) || load_out);
  assign accept     = in_valid_i && !in_stall_o;

  // step sequencer
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    unique case (st_q)
      ST_RUN: begin
        if (step_q == STEP_TERM) begin
          st_d   = ST_DONE;
          step_d = STEP_ENV;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          st_d = ST_IDLE;
        end
      end
      default: ;
    endcase
    if (accept) begin
      st_d   = ST_RUN;
      step_d = STEP_ENV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= STEP_ENV;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  assign ctrl.step_env  = (st_q == ST_RUN) && (step_q == STEP_ENV);
  assign ctrl.step_xd   = (st_q == ST_RUN) && (step_q == STEP_XD);
  assign ctrl.step_term = (st_q == ST_RUN) && (step_q == STEP_TERM);

  // frame samples, held for the whole computation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q[0] <= left_sample_i;
      x_q[1] <= right_sample_i;
    end
  end

  // one lane per shaped channel, the rest pass through
  for (genvar ch = 0; ch < sts_pkg::NUM_CH; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_shape
      sts_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .x_i   (x_q[ch]),
        .cfg_i (cfg_q),
        .ctrl_i(ctrl),
        .y_o   (res[ch])
      );
    end else begin : g_pass
      assign res[ch] = x_q[ch];
    end
  end

  sts_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load_out),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .left_result_o (left_result_o),
    .right_result_o(right_result_o)
  );

  // an accepted frame starts at the envelope step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_RUN) && (step_q == STEP_ENV))
    else $error("accepted frame did not start its steps");

  // the last step always hands over to the output stage
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_RUN) && (step_q == STEP_TERM)) |=> (st_q == ST_DONE))
    else $error("frame did not reach the output stage");

  // a finished frame stays until the output register takes it
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_DONE) && out_valid_o && out_stall_i) |=> (st_q == ST_DONE))
    else $error("finished frame dropped while output stalled");

endmodule

`default_nettype wire
